### hw/rtl/tls_pkg.sv
// ----------------------------------------------------------------------------
// Tilt leveling sequencer package
// Shared codes, record types and the leg pair lookup for the sequencer.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned TiltW  = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned StepW  = 15;
  localparam int unsigned LegW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 15;

  localparam logic [CountW-1:0] CountMax = '1;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] MaxAttemptsRst    = 4'd12;
  localparam logic [CountW-1:0] MaxBadReadingsRst = 4'd8;
  localparam logic [StepW-1:0]  MaxStepRst        = 15'd41;
  localparam logic              SensorFaceUpRst   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ATTEMPTS     = 2'd0,
    CFG_MAX_BAD_READINGS = 2'd1,
    CFG_MAX_STEP         = 2'd2,
    CFG_SENSOR_FACE_UP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_BALANCE = 3'd1,
    FUNC_ZERO    = 3'd2,
    FUNC_FINAL   = 3'd3,
    FUNC_GROUND  = 3'd4,
    FUNC_STOP    = 3'd5
  } func_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE      = 4'd0,
    MODE_ZERO      = 4'd1,
    MODE_BALANCED  = 4'd2,
    MODE_ERROR     = 4'd3,
    MODE_GROUND    = 4'd4,
    MODE_FINAL     = 4'd5,
    MODE_BALANCING = 4'd6,
    MODE_TO_ZERO   = 4'd7,
    MODE_TO_GROUND = 4'd8,
    MODE_TO_FINAL  = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    MOVE_BUSY  = 2'd0,
    MOVE_DONE  = 2'd1,
    MOVE_ERROR = 2'd2
  } move_status_e;

  typedef enum logic [1:0] {
    START_NONE   = 2'd0,
    START_ZERO   = 2'd1,
    START_FINAL  = 2'd2,
    START_GROUND = 2'd3
  } move_start_e;

  typedef struct packed {
    logic [CountW-1:0] max_attempts;
    logic [CountW-1:0] max_bad_readings;
    logic [StepW-1:0]  max_step;
    logic              sensor_face_up;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic                    update_due;
    logic signed [TiltW-1:0] pitch;
    logic signed [TiltW-1:0] roll;
    logic                    level_ok;
    logic                    pitch_ok;
    logic                    roll_ok;
    logic                    leg_at_end;
    logic [1:0]              move_status;
  } item_t;

  typedef struct packed {
    mode_e                   mode;
    logic                    axis_active;
    logic                    axis_is_roll;
    logic signed [TiltW-1:0] last_good_tilt;
    logic [CountW-1:0]       attempts;
    logic [CountW-1:0]       bad_count;
  } state_t;

  typedef struct packed {
    mode_e             mode;
    logic              stop_motors;
    logic              expand_valid;
    logic [LegW-1:0]   first_leg;
    logic [LegW-1:0]   second_leg;
    move_start_e       move_start;
    logic [CountW-1:0] attempt_count;
  } result_t;

  // Leg pair to expand, indexed by {face_up, is_roll, tilt_positive}.
  // Each entry is {first_leg, second_leg}.
  localparam logic [2*LegW-1:0] LegPairs [8] = '{
    4'b00_01,  // face down, pitch, not positive: A, B
    4'b10_11,  // face down, pitch, positive: C, D
    4'b00_10,  // face down, roll, not positive: A, C
    4'b11_01,  // face down, roll, positive: D, B
    4'b11_01,  // face up, pitch, not positive: D, B
    4'b00_10,  // face up, pitch, positive: A, C
    4'b10_11,  // face up, roll, not positive: C, D
    4'b00_01   // face up, roll, positive: A, B
  };

  function automatic logic [2*LegW-1:0] leg_pair(input logic face_up, input logic is_roll,
                                                 input logic positive);
    return LegPairs[{face_up, is_roll, positive}];
  endfunction

  function automatic logic [TiltW:0] tilt_mag(input logic signed [TiltW-1:0] v);
    logic signed [TiltW:0] ext;
    ext = {v[TiltW-1], v};
    return ext[TiltW] ? (TiltW+1)'(-ext) : ext;
  endfunction

endpackage

### hw/rtl/tls_cfg_regs.sv
// ----------------------------------------------------------------------------
// Tilt leveling sequencer configuration registers
// Holds the attempt and bad reading limits, the step limit and the mounting.
// ----------------------------------------------------------------------------
module tls_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tls_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tls_pkg::CfgDatW-1:0]  cfg_data_i,
  output tls_pkg::cfg_t                cfg_o
);

  tls_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tls_pkg::CFG_MAX_ATTEMPTS:
          cfg_d.max_attempts = cfg_data_i[tls_pkg::CountW-1:0];
        tls_pkg::CFG_MAX_BAD_READINGS:
          cfg_d.max_bad_readings = cfg_data_i[tls_pkg::CountW-1:0];
        tls_pkg::CFG_MAX_STEP:
          cfg_d.max_step = cfg_data_i[tls_pkg::StepW-1:0];
        tls_pkg::CFG_SENSOR_FACE_UP:
          cfg_d.sensor_face_up = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts     <= tls_pkg::MaxAttemptsRst;
      cfg_q.max_bad_readings <= tls_pkg::MaxBadReadingsRst;
      cfg_q.max_step         <= tls_pkg::MaxStepRst;
      cfg_q.sensor_face_up   <= tls_pkg::SensorFaceUpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/tls_step.sv
// ----------------------------------------------------------------------------
// Tilt leveling sequencer step logic
// Computes the next sequencer state and the result word for one input word.
// ----------------------------------------------------------------------------
module tls_step (
  input  tls_pkg::cfg_t    cfg_i,
  input  tls_pkg::item_t   item_i,
  input  tls_pkg::state_t  state_i,
  output tls_pkg::state_t  state_o,
  output tls_pkg::result_t result_o
);

  logic [tls_pkg::TiltW:0]          pitch_mag, roll_mag;
  logic                             pick_roll;
  logic signed [tls_pkg::TiltW-1:0] pick_tilt;
  logic [2*tls_pkg::LegW-1:0]       pair;

  logic                             act, sel_roll, axis_ok, bad;
  logic signed [tls_pkg::TiltW-1:0] last, now;
  logic [tls_pkg::CountW-1:0]       bc, att;
  logic signed [tls_pkg::TiltW:0]   now_x, last_x, diff;
  logic                             dir_ok;

  // Axis choice for a fresh attempt: the larger tilt, roll on a tie.
  assign pitch_mag = tls_pkg::tilt_mag(item_i.pitch);
  assign roll_mag  = tls_pkg::tilt_mag(item_i.roll);
  assign pick_roll = !(pitch_mag > roll_mag);
  assign pick_tilt = pick_roll ? item_i.roll : item_i.pitch;
  assign pair      = tls_pkg::leg_pair(cfg_i.sensor_face_up, pick_roll,
                                       (pick_tilt > 0));

  // Track the axis, reference tilt and counters as a fresh attempt leaves them.
  assign act      = 1'b1;
  assign sel_roll = state_i.axis_active ? state_i.axis_is_roll : pick_roll;
  assign last     = state_i.axis_active ? state_i.last_good_tilt : pick_tilt;
  assign axis_ok  = sel_roll ? item_i.roll_ok : item_i.pitch_ok;
  assign now      = sel_roll ? item_i.roll : item_i.pitch;

  // A good reading moves strictly toward zero by no more than the step limit.
  assign now_x  = {now[tls_pkg::TiltW-1], now};
  assign last_x = {last[tls_pkg::TiltW-1], last};
  assign dir_ok = last[tls_pkg::TiltW-1] ? (now > last) : (now < last);
  assign diff   = last[tls_pkg::TiltW-1] ? (now_x - last_x) : (last_x - now_x);
  assign bad    = (now == last) || !dir_ok ||
                  (diff[tls_pkg::TiltW:0] > {2'b00, cfg_i.max_step});

  always_comb begin
    bc  = state_i.axis_active ? state_i.bad_count : '0;
    att = state_i.attempts;
    if (!state_i.axis_active && (state_i.attempts != tls_pkg::CountMax)) begin
      att = state_i.attempts + 1'b1;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.mode       = state_i.mode;
    result_o.move_start = tls_pkg::START_NONE;

    case (item_i.func)
      tls_pkg::FUNC_TICK: begin
        if (state_i.mode == tls_pkg::MODE_BALANCING) begin
          if (item_i.update_due) begin
            if (item_i.level_ok) begin
              result_o.stop_motors = 1'b1;
              state_o.mode         = tls_pkg::MODE_BALANCED;
            end else if (item_i.leg_at_end ||
                         (state_i.attempts >= cfg_i.max_attempts)) begin
              result_o.stop_motors = 1'b1;
              state_o.mode         = tls_pkg::MODE_ERROR;
            end else begin
              state_o.axis_active  = act;
              state_o.axis_is_roll = sel_roll;
              state_o.attempts     = att;
              state_o.last_good_tilt = last;
              state_o.bad_count    = bc;
              if (!state_i.axis_active) begin
                result_o.stop_motors  = 1'b1;
                result_o.expand_valid = 1'b1;
                result_o.first_leg    = pair[2*tls_pkg::LegW-1:tls_pkg::LegW];
                result_o.second_leg   = pair[tls_pkg::LegW-1:0];
              end
              if (axis_ok) begin
                result_o.stop_motors  = 1'b1;
                result_o.expand_valid = 1'b0;
                state_o.axis_active   = 1'b0;
              end else if (!bad) begin
                state_o.last_good_tilt = now;
                state_o.bad_count      = '0;
              end else begin
                if (bc != tls_pkg::CountMax) begin
                  state_o.bad_count = bc + 1'b1;
                end
                if (state_o.bad_count > cfg_i.max_bad_readings) begin
                  result_o.stop_motors  = 1'b1;
                  result_o.expand_valid = 1'b0;
                  state_o.axis_active   = 1'b0;
                end
              end
            end
          end
        end else if ((state_i.mode == tls_pkg::MODE_TO_ZERO) ||
                     (state_i.mode == tls_pkg::MODE_TO_GROUND) ||
                     (state_i.mode == tls_pkg::MODE_TO_FINAL)) begin
          if (item_i.move_status == tls_pkg::MOVE_DONE) begin
            if (state_i.mode == tls_pkg::MODE_TO_ZERO) begin
              state_o.mode = tls_pkg::MODE_ZERO;
            end else if (state_i.mode == tls_pkg::MODE_TO_GROUND) begin
              state_o.mode = tls_pkg::MODE_GROUND;
            end else begin
              state_o.mode = tls_pkg::MODE_FINAL;
            end
          end else if (item_i.move_status == tls_pkg::MOVE_ERROR) begin
            state_o.mode = tls_pkg::MODE_ERROR;
          end
        end
      end
      tls_pkg::FUNC_BALANCE: begin
        state_o.attempts    = '0;
        state_o.axis_active = 1'b0;
        state_o.mode        = tls_pkg::MODE_BALANCING;
      end
      tls_pkg::FUNC_ZERO: begin
        state_o.mode        = tls_pkg::MODE_TO_ZERO;
        result_o.move_start = tls_pkg::START_ZERO;
      end
      tls_pkg::FUNC_FINAL: begin
        state_o.mode        = tls_pkg::MODE_TO_FINAL;
        result_o.move_start = tls_pkg::START_FINAL;
      end
      tls_pkg::FUNC_GROUND: begin
        state_o.mode        = tls_pkg::MODE_TO_GROUND;
        result_o.move_start = tls_pkg::START_GROUND;
      end
      tls_pkg::FUNC_STOP: begin
        state_o.mode         = tls_pkg::MODE_NONE;
        result_o.stop_motors = 1'b1;
      end
      default: ;
    endcase

    // Legs are only reported with an expand request.
    if (!result_o.expand_valid) begin
      result_o.first_leg  = '0;
      result_o.second_leg = '0;
    end
    result_o.mode          = state_o.mode;
    result_o.attempt_count = state_o.attempts;
  end

endmodule

### hw/rtl/tilt_leveling_sequencer.sv
// ----------------------------------------------------------------------------
// Tilt leveling sequencer
// Mode sequencer and leg pair selection for leveling a four-leg platform.
// ----------------------------------------------------------------------------
// Each input word produces exactly one result word. A word is captured in an
// input register; the step logic then updates the sequencer state and fills
// the result register, and a new word is taken in every cycle: the rate is
// one word per cycle unless out_stall_i holds the result register. When the
// result register is held by out_stall_i the input register keeps its word
// and in_stall_o is raised.
// Configuration writes are taken in any cycle but belong to idle periods.
// ----------------------------------------------------------------------------
module tilt_leveling_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tls_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tls_pkg::CfgDatW-1:0]       cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tls_pkg::FuncW-1:0]         func_i,
  input  logic                              update_due_i,
  input  logic signed [tls_pkg::TiltW-1:0]  pitch_i,
  input  logic signed [tls_pkg::TiltW-1:0]  roll_i,
  input  logic                              level_ok_i,
  input  logic                              pitch_ok_i,
  input  logic                              roll_ok_i,
  input  logic                              leg_at_end_i,
  input  logic [1:0]                        move_status_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tls_pkg::ModeW-1:0]         mode_o,
  output logic                              stop_motors_o,
  output logic                              expand_valid_o,
  output logic [tls_pkg::LegW-1:0]          first_leg_o,
  output logic [tls_pkg::LegW-1:0]          second_leg_o,
  output logic [1:0]                        move_start_o,
  output logic [tls_pkg::CountW-1:0]        attempt_count_o
);

  tls_pkg::cfg_t    cfg;
  tls_pkg::item_t   item_d, item_q;
  tls_pkg::state_t  state_d, state_q;
  tls_pkg::result_t result_d, result_q;
  logic             item_vld_q, out_vld_q;
  logic             out_free, advance, take;

  tls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tls_step u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The result register frees up when it is empty or its word is taken.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = item_vld_q && out_free;
  assign in_stall_o = item_vld_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  assign item_d.func        = func_i;
  assign item_d.update_due  = update_due_i;
  assign item_d.pitch       = pitch_i;
  assign item_d.roll        = roll_i;
  assign item_d.level_ok    = level_ok_i;
  assign item_d.pitch_ok    = pitch_ok_i;
  assign item_d.roll_ok     = roll_ok_i;
  assign item_d.leg_at_end  = leg_at_end_i;
  assign item_d.move_status = move_status_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (take) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mode_o          = result_q.mode;
  assign stop_motors_o   = result_q.stop_motors;
  assign expand_valid_o  = result_q.expand_valid;
  assign first_leg_o     = result_q.first_leg;
  assign second_leg_o    = result_q.second_leg;
  assign move_start_o    = result_q.move_start;
  assign attempt_count_o = result_q.attempt_count;

endmodule
